/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked on the following clock edge.
`define LEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication with a delayed consequent.
`define LEC_ASSERT_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("assertion failed");

`endif

/* design/lec_pkg.sv */
`default_nettype none
package lec_pkg;

   localparam int GAMMA_TENTHS = 22;
   localparam int GAMMA_INT    = GAMMA_TENTHS / 10;
   localparam int GAMMA_FRAC   = GAMMA_TENTHS % 10;

   localparam int LUT_DEPTH = 101;
   localparam int DUTY_W    = 10;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
   localparam logic signed [7:0] LEVEL_MAX = 8'sd100;
   localparam logic signed [7:0] LEVEL_MIN = -8'sd100;

   // operating modes
   localparam logic [2:0] MODE_STEADY = 3'd0;
   localparam logic [2:0] MODE_BLINK  = 3'd1;
   localparam logic [2:0] MODE_CYCLIC = 3'd2;
   localparam logic [2:0] MODE_SINGLE = 3'd3;
   localparam logic [2:0] MODE_BREATH = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PON    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PPER   = 3'd4;

   // input commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef logic [LUT_DEPTH-1:0][DUTY_W-1:0] gamma_lut_type;

   function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   function automatic logic [63:0] q_pow(logic [63:0] x, int n);
      logic [63:0] r;
      r = Q30_ONE;
      for (int i = 0; i < n; i++) begin
         r = q_mul(r, x);
      end
      return r;
   endfunction

   // largest Q30 r in [0, 1] with r^10 <= v
   function automatic logic [63:0] q_root10(logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'd0;
      hi = Q30_ONE;
      while (lo < hi) begin
         mid = lo + (hi - lo + 64'd1) / 2;
         if (q_pow(mid, 10) <= v) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   // evaluated at elaboration only
   function automatic gamma_lut_type build_gamma_lut();
      gamma_lut_type lut;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] d;
      lut = '0;
      for (int p = 0; p < LUT_DEPTH; p++) begin
         x = (64'(p) << 30) / 100;
         y = q_mul(q_pow(x, GAMMA_INT), q_root10(q_pow(x, GAMMA_FRAC)));
         d = (y * 64'd1000 + (Q30_ONE >> 1)) >> 30;
         if (d > 64'd1000) begin
            d = 64'd1000;
         end
         lut[p] = d[DUTY_W-1:0];
      end
      return lut;
   endfunction

   localparam gamma_lut_type GAMMA_LUT = build_gamma_lut();

endpackage
`default_nettype wire

/* design/lec_if.sv */
`default_nettype none
interface lec_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] now_ms;

   modport source (output valid, output command, output now_ms, input ready);
   modport sink   (input valid, input command, input now_ms, output ready);
endinterface

interface lec_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         pwm_enable;
   logic [lec_pkg::DUTY_W-1:0]   duty_tenths;

   modport source (output valid, output pwm_enable, output duty_tenths, input ready);
   modport sink   (input valid, input pwm_enable, input duty_tenths, output ready);
endinterface
`default_nettype wire

/* design/led_effect_controller.sv */
// LED effect controller. Each request carries a command (tick or single-pulse
// start) and a millisecond time stamp; each produces exactly one response with
// the PWM enable and gamma-corrected duty (tenths of a percent) after that
// request. Modes: steady, blink, cyclic pulse, single pulse, breathe, chosen
// through the csr_ write port, which may only be used while the block is idle.
// Without backpressure the block takes one request per clock: the request sits
// in an input register, and the mode update (one 32-bit time subtract and
// compare, gamma table lookup) runs from there into the response register
// when that register is empty or being read. The input register also absorbs
// one request while a response is held by a stalled consumer.
`default_nettype none
module led_effect_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lec_req_if.sink                                req_chan,
   lec_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [lec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lec_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   // configuration
   logic [2:0]                  mode_ff, mode_in;
   logic [lec_pkg::PCT_W-1:0]   bright_ff, bright_in;
   logic [15:0]                 blink_ff, blink_in;
   logic [31:0]                 pon_ff, pon_in;
   logic [31:0]                 pper_ff, pper_in;
   logic                        csr_hit;

   // effect state
   logic                        lit_ff, lit_in;
   logic                        enable_ff, enable_in;
   logic [lec_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic [31:0]                 last_ff, last_in;
   logic [1:0]                  edges_ff, edges_in;
   logic signed [7:0]           level_ff, level_in;

   // pipeline
   logic                        s1_valid_ff;
   logic                        s1_cmd_ff;
   logic [31:0]                 s1_now_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_enable_ff;
   logic [lec_pkg::DUTY_W-1:0]  rsp_duty_ff;
   logic                        advance;
   logic                        req_xfer;

   // tick datapath
   logic [31:0]                 elapsed;
   logic [31:0]                 pulse_wait;
   logic                        pulse_ok;
   logic [lec_pkg::PCT_W-1:0]   clamp_pct;
   logic signed [7:0]           level_adj;
   logic signed [7:0]           level_abs;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pwm_enable  = rsp_enable_ff;
   assign rsp_chan.duty_tenths = rsp_duty_ff;

   assign clamp_pct = (csr_wdata[lec_pkg::PCT_W-1:0] > lec_pkg::PCT_MAX) ?
                      lec_pkg::PCT_MAX : csr_wdata[lec_pkg::PCT_W-1:0];

   // configuration decode
   always_comb begin
      mode_in   = mode_ff;
      bright_in = bright_ff;
      blink_in  = blink_ff;
      pon_in    = pon_ff;
      pper_in   = pper_ff;
      csr_hit   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            lec_pkg::CSR_MODE: begin
               mode_in = csr_wdata[2:0];
               csr_hit = 1'b1;
            end
            lec_pkg::CSR_BRIGHT: begin
               bright_in = clamp_pct;
               csr_hit   = 1'b1;
            end
            lec_pkg::CSR_BLINK: begin
               blink_in = csr_wdata[15:0];
               csr_hit  = 1'b1;
            end
            lec_pkg::CSR_PON: begin
               pon_in  = csr_wdata;
               csr_hit = 1'b1;
            end
            lec_pkg::CSR_PPER: begin
               pper_in = csr_wdata;
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   assign elapsed    = s1_now_ff - last_ff;
   assign pulse_wait = lit_ff ? pon_ff : (pper_ff - pon_ff);
   assign pulse_ok   = (pon_ff != 32'd0) && (pper_ff >= pon_ff) &&
                       !((mode_ff == lec_pkg::MODE_SINGLE) && (edges_ff >= 2'd2));
   assign level_adj  = (level_ff > lec_pkg::LEVEL_MAX) ? lec_pkg::LEVEL_MIN : level_ff;
   assign level_abs  = (level_adj < 0) ? -level_adj : level_adj;

   // effect update for a configuration write or the item leaving the input register
   always_comb begin
      lit_in    = lit_ff;
      enable_in = enable_ff;
      duty_in   = duty_ff;
      last_in   = last_ff;
      edges_in  = edges_ff;
      level_in  = level_ff;
      if (csr_hit) begin
         lit_in    = (mode_in == lec_pkg::MODE_BREATH);
         enable_in = (mode_in == lec_pkg::MODE_BREATH);
         level_in  = 8'(signed'({1'b0, bright_in}));
      end else if (advance) begin
         if (s1_cmd_ff == lec_pkg::CMD_START) begin
            if (mode_ff == lec_pkg::MODE_SINGLE) begin
               lit_in    = 1'b0;
               enable_in = 1'b0;
               edges_in  = 2'd0;
            end
         end else begin
            case (mode_ff) inside
               lec_pkg::MODE_STEADY: begin
                  if (bright_ff == '0) begin
                     enable_in = 1'b0;
                  end else begin
                     enable_in = 1'b1;
                     duty_in   = lec_pkg::GAMMA_LUT[bright_ff];
                  end
               end
               lec_pkg::MODE_BLINK: begin
                  if ((blink_ff != 16'd0) && (elapsed >= {16'd0, blink_ff})) begin
                     last_in   = s1_now_ff;
                     lit_in    = !lit_ff;
                     enable_in = !lit_ff;
                  end
               end
               lec_pkg::MODE_CYCLIC, lec_pkg::MODE_SINGLE: begin
                  if (pulse_ok && (elapsed >= pulse_wait)) begin
                     last_in   = s1_now_ff;
                     lit_in    = !lit_ff;
                     enable_in = !lit_ff;
                     if (mode_ff == lec_pkg::MODE_SINGLE) begin
                        edges_in = edges_ff + 2'd1;
                     end
                  end
               end
               lec_pkg::MODE_BREATH: begin
                  duty_in  = lec_pkg::GAMMA_LUT[level_abs[lec_pkg::PCT_W-1:0]];
                  level_in = level_adj + 8'sd1;
               end
               default: begin
                  lit_in = lit_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lec_pkg::MODE_STEADY;
         bright_ff    <= '0;
         blink_ff     <= '0;
         pon_ff       <= '0;
         pper_ff      <= '0;
         lit_ff       <= 1'b0;
         enable_ff    <= 1'b0;
         duty_ff      <= '0;
         last_ff      <= '0;
         edges_ff     <= '0;
         level_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         bright_ff <= bright_in;
         blink_ff  <= blink_in;
         pon_ff    <= pon_in;
         pper_ff   <= pper_in;
         lit_ff    <= lit_in;
         enable_ff <= enable_in;
         duty_ff   <= duty_in;
         last_ff   <= last_in;
         edges_ff  <= edges_in;
         level_ff  <= level_in;
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff <= req_chan.command;
         s1_now_ff <= req_chan.now_ms;
      end
      if (advance) begin
         rsp_enable_ff <= enable_in;
         rsp_duty_ff   <= duty_in;
      end
   end

endmodule
`default_nettype wire

/* design/lec_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module lec_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_enable,
   input wire logic [lec_pkg::DUTY_W-1:0]      rsp_duty
);

   // duty never exceeds full scale
   `LEC_ASSERT_NOW(a_duty_range, clock, reset, rsp_valid, rsp_duty <= 10'd1000)

   // an empty response register means the block can take a request
   `LEC_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // an item accepted with the output empty is followed by a valid response
   `LEC_ASSERT_TWO(a_rsp_follows, clock, reset,
      req_valid && req_ready && !rsp_valid, rsp_valid)

   // stalled response holds
   `LEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_enable) && $stable(rsp_duty))

endmodule

bind led_effect_controller lec_checker u_lec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_enable (rsp_chan.pwm_enable),
   .rsp_duty   (rsp_chan.duty_tenths)
);
`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
   import lec_pkg::*;

   typedef struct packed {
      logic        command;
      logic [31:0] now_ms;
   } led_req_type;

   typedef struct packed {
      logic              pwm_enable;
      logic [DUTY_W-1:0] duty_tenths;
   } led_out_type;

   localparam logic [2:0]           MODE_BAD = 3'd7;   // highest unused mode code
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 3'd5;   // first index past the register file
   localparam logic [CSR_IDX_W-1:0] CSR_LAST = 3'd7;
   localparam logic [63:0]          FX_ONE   = 64'h4000_0000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   lec_req_if req_if ();
   lec_rsp_if rsp_if ();

   led_effect_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   led_req_type pending_q[$];
   led_out_type expect_q[$];
   led_req_type next_item;
   led_out_type want;
   bit          req_busy;        // item on the bus, not yet transferred
   bit          hold_go;
   logic        rsp_hold = 1'b0;
   int          fail_count;
   int          src_gap_pct;
   int          snk_stall_pct;
   logic [31:0] ms_base;

   // predictor: configuration and state
   logic [2:0]        cfg_mode;
   logic [PCT_W-1:0]  cfg_bright;
   logic [15:0]       cfg_blink;
   logic [31:0]       cfg_on;
   logic [31:0]       cfg_period;
   logic              lit_now;
   logic              enable_now;
   logic [DUTY_W-1:0] duty_now;
   logic [31:0]       last_toggle_ms;
   logic [1:0]        toggle_count;
   logic signed [7:0] breath_level;
   logic [DUTY_W-1:0] duty_curve [0:LUT_DEPTH-1];

   // truncated Q30 power
   function automatic logic [63:0] fx_pow(logic [63:0] base, int n);
      logic [63:0] acc;
      acc = FX_ONE;
      repeat (n) acc = (acc * base) >> 30;
      return acc;
   endfunction

   // largest Q30 value in [0, 1] whose tenth power stays at or below v
   function automatic logic [63:0] fx_root10(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] trial;
      r = 64'd0;
      if (v >= FX_ONE) return FX_ONE;
      for (int b = 29; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (fx_pow(trial, 10) <= v) r = trial;
      end
      return r;
   endfunction

   function automatic logic [DUTY_W-1:0] gamma_duty(int pct);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] d;
      x = (64'(pct) << 30) / 100;
      y = (fx_pow(x, GAMMA_TENTHS / 10) * fx_root10(fx_pow(x, GAMMA_TENTHS % 10))) >> 30;
      d = (y * 1000 + (FX_ONE >> 1)) >> 30;
      if (d > 1000) d = 1000;
      return d[DUTY_W-1:0];
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
         CSR_MODE:   cfg_mode = data[2:0];
         CSR_BRIGHT: cfg_bright = (data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : data[PCT_W-1:0];
         CSR_BLINK:  cfg_blink = data[15:0];
         CSR_PON:    cfg_on = data;
         CSR_PPER:   cfg_period = data;
         default:    return;
      endcase
      lit_now      = (cfg_mode == MODE_BREATH);
      enable_now   = lit_now;
      breath_level = signed'({1'b0, cfg_bright});
   endfunction

   function automatic void flip_at(logic [31:0] now);
      last_toggle_ms = now;
      lit_now        = ~lit_now;
      enable_now     = lit_now;
   endfunction

   function automatic led_out_type led_step(logic cmd, logic [31:0] now);
      logic [31:0] since;
      logic [31:0] hold_ms;
      int          mag;
      led_out_type res;
      since = now - last_toggle_ms;
      if (cmd == CMD_START) begin
         if (cfg_mode == MODE_SINGLE) begin
            enable_now   = 1'b0;
            lit_now      = 1'b0;
            toggle_count = 2'd0;
         end
      end else begin
         case (cfg_mode) inside
            MODE_STEADY: begin
               if (cfg_bright == 0) begin
                  enable_now = 1'b0;
               end else begin
                  enable_now = 1'b1;
                  duty_now   = duty_curve[cfg_bright];
               end
            end
            MODE_BLINK: begin
               if (cfg_blink != 0 && since >= 32'(cfg_blink)) flip_at(now);
            end
            MODE_CYCLIC, MODE_SINGLE: begin
               if (cfg_on != 0 && cfg_period >= cfg_on &&
                   !(cfg_mode == MODE_SINGLE && toggle_count >= 2)) begin
                  hold_ms = lit_now ? cfg_on : cfg_period - cfg_on;
                  if (since >= hold_ms) begin
                     flip_at(now);
                     if (cfg_mode == MODE_SINGLE) toggle_count++;
                  end
               end
            end
            MODE_BREATH: begin
               if (breath_level > LEVEL_MAX) breath_level = LEVEL_MIN;
               mag = (breath_level < 0) ? -int'(breath_level) : int'(breath_level);
               duty_now = duty_curve[mag];
               breath_level++;
            end
            default: ;
         endcase
      end
      res.pwm_enable  = enable_now;
      res.duty_tenths = duty_now;
      return res;
   endfunction

   task automatic send(logic cmd, logic [31:0] now);
      led_req_type it;
      it.command = cmd;
      it.now_ms  = now;
      pending_q.push_back(it);
   endtask

   // wait until every item is transferred and every response is back
   task automatic settle();
      while (pending_q.size() != 0 || req_busy || expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      settle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, data);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_busy = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expect_q.push_back(led_step(req_if.command, req_if.now_ms));
            req_busy = 1'b0;
         end
         if (!req_busy && pending_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
            next_item = pending_q.pop_front();
            req_if.valid   <= 1'b1;
            req_if.command <= next_item.command;
            req_if.now_ms  <= next_item.now_ms;
            req_busy = 1'b1;
         end else if (!req_busy) begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expect_q.size() == 0) begin
               $error("unexpected response: pwm_enable %0b duty_tenths %0d",
                      rsp_if.pwm_enable, rsp_if.duty_tenths);
               fail_count++;
            end else begin
               want = expect_q.pop_front();
               if (rsp_if.pwm_enable !== want.pwm_enable) begin
                  $error("pwm_enable: expected %0b, actual %0b",
                         want.pwm_enable, rsp_if.pwm_enable);
                  fail_count++;
               end
               if (rsp_if.duty_tenths !== want.duty_tenths) begin
                  $error("duty_tenths: expected %0d, actual %0d",
                         want.duty_tenths, rsp_if.duty_tenths);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // long consumer stall so the block backs up into its request side
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("led_effect_controller: mismatch");
      $finish;
   end

   initial begin : stimulus
      int          n;
      int          r;
      logic [31:0] val;
      logic [2:0]  mode_pick;
      logic        start_bit;

      csr_we         = 1'b0;
      csr_index      = CSR_MODE;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.command = CMD_TICK;
      req_if.now_ms  = '0;
      rsp_if.ready   = 1'b0;
      hold_go        = 1'b0;
      fail_count     = 0;
      src_gap_pct    = 34;
      snk_stall_pct  = 50;
      ms_base        = '0;

      cfg_mode       = MODE_STEADY;
      cfg_bright     = '0;
      cfg_blink      = '0;
      cfg_on         = '0;
      cfg_period     = '0;
      lit_now        = 1'b0;
      enable_now     = 1'b0;
      duty_now       = '0;
      last_toggle_ms = '0;
      toggle_count   = '0;
      breath_level   = '0;
      for (int p = 0; p < LUT_DEPTH; p++) duty_curve[p] = gamma_duty(p);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // steady brightness, including the clamp on writes above full scale
      send(CMD_TICK, 32'd0);
      write_reg(CSR_BRIGHT, 32'hFFFF_FF7F);
      send(CMD_TICK, 32'd1);
      write_reg(CSR_BRIGHT, 32'd1);
      send(CMD_TICK, 32'd2);
      send(CMD_START, 32'd3);

      // blink at the longest half period, across the time stamp wrap
      write_reg(CSR_MODE, 32'(MODE_BLINK));
      write_reg(CSR_BLINK, 32'hABCD_FFFF);
      send(CMD_TICK, 32'd65534);
      send(CMD_TICK, 32'd65535);
      send(CMD_TICK, 32'hFFFF_FFFF);
      send(CMD_TICK, 32'd65534);
      write_reg(CSR_BLINK, 32'd0);
      send(CMD_TICK, 32'h8000_0000);

      // cyclic pulse: zero on time, period below on time, then normal toggling
      write_reg(CSR_MODE, 32'(MODE_CYCLIC));
      write_reg(CSR_PON, 32'd0);
      write_reg(CSR_PPER, 32'd10);
      send(CMD_TICK, 32'h7000_0000);
      write_reg(CSR_PON, 32'd20);
      send(CMD_TICK, 32'h7000_0000);
      write_reg(CSR_PPER, 32'd30);
      send(CMD_TICK, 32'd65544);
      send(CMD_TICK, 32'd65564);
      write_reg(CSR_PON, 32'hFFFF_FFFF);
      write_reg(CSR_PPER, 32'hFFFF_FFFF);
      send(CMD_TICK, 32'd65565);
      send(CMD_TICK, 32'd65566);

      // single pulse: it turns on, then off, then stops until the next start
      write_reg(CSR_MODE, 32'(MODE_SINGLE));
      write_reg(CSR_PON, 32'd5);
      write_reg(CSR_PPER, 32'd10);
      send(CMD_START, 32'd70000);
      send(CMD_TICK, 32'd70005);
      send(CMD_TICK, 32'd70010);
      send(CMD_TICK, 32'd70100);
      send(CMD_START, 32'd70101);
      send(CMD_TICK, 32'd70110);

      // breathe from the top level through the wrap to the bottom
      write_reg(CSR_BRIGHT, 32'd100);
      write_reg(CSR_MODE, 32'(MODE_BREATH));
      send(CMD_TICK, 32'd1);
      send(CMD_TICK, 32'd2);
      send(CMD_TICK, 32'd3);

      // unused mode, and writes past the register file
      write_reg(CSR_MODE, 32'(MODE_BAD));
      send(CMD_TICK, 32'd4);
      write_reg(CSR_NONE, 32'hFFFF_FFFF);
      write_reg(CSR_LAST, 32'd0);
      send(CMD_START, 32'd5);

      for (int b = 0; b < 40; b++) begin
         settle();
         if (b < 13) begin
            src_gap_pct   = 34;
            snk_stall_pct = 50;
         end else if (b < 26) begin
            src_gap_pct   = 50;
            snk_stall_pct = 34;
         end else begin
            src_gap_pct   = 0;
            snk_stall_pct = 0;
         end

         mode_pick = ($urandom_range(19) == 0) ?
                     3'($urandom_range(MODE_BREATH + 1, MODE_BAD)) :
                     3'($urandom_range(MODE_BREATH));
         write_reg(CSR_MODE, 32'(mode_pick));
         if ($urandom_range(1) != 0) begin
            val = $urandom();
            case ($urandom_range(3))
               0: val[PCT_W-1:0] = '0;
               1: val[PCT_W-1:0] = PCT_MAX;
               default: ;
            endcase
            write_reg(CSR_BRIGHT, val);
         end
         if ($urandom_range(1) != 0) begin
            val = $urandom();
            r = $urandom_range(9);
            if (r == 0) val[15:0] = '0;
            else if (r == 1) val[15:0] = 16'hFFFF;
            else if (r > 2) val[15:0] = 16'($urandom_range(1, 12));
            write_reg(CSR_BLINK, val);
         end
         if ($urandom_range(1) != 0) begin
            r = $urandom_range(9);
            if (r == 0) val = '0;
            else if (r == 1) val = 32'hFFFF_FFFF;
            else if (r == 2) val = $urandom();
            else val = $urandom_range(1, 8);
            write_reg(CSR_PON, val);
         end
         if ($urandom_range(1) != 0) begin
            r = $urandom_range(9);
            if (r == 0) val = cfg_on - 1;
            else if (r == 1) val = 32'hFFFF_FFFF;
            else if (r == 2) val = $urandom();
            else val = cfg_on + $urandom_range(0, 10);
            write_reg(CSR_PPER, val);
         end
         if ($urandom_range(9) == 0) write_reg(CSR_IDX_W'($urandom_range(CSR_NONE, CSR_LAST)),
                                               $urandom());

         if (b % 8 == 3) ms_base = 32'hFFFF_FFE0;
         n = (b == 5) ? 60 : 24;
         if (b == 5) hold_go = 1'b1;
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 3) ms_base = $urandom();
            else ms_base += $urandom_range(0, 6);
            start_bit = ($urandom_range(99) < ((cfg_mode == MODE_SINGLE) ? 15 : 5)) ?
                        CMD_START : CMD_TICK;
            // a few stray stamps out of sequence
            if (r >= 97) send(start_bit, $urandom());
            else send(start_bit, ms_base);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expect_q.size() == 0) begin
         $display("led_effect_controller: match");
      end else begin
         $display("led_effect_controller: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/lec_pkg.sv
design/lec_if.sv
design/led_effect_controller.sv
design/lec_checker.sv
sim/tb_top.sv
